@@ sv/aabb_pair_contact_tracker_core_macros.svh @@
// Assertion macros used by the contact tracker top level.
`ifndef AABB_PAIR_CONTACT_TRACKER_CORE_MACROS_SVH
`define AABB_PAIR_CONTACT_TRACKER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define APCT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define APCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define APCT_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

@@ sv/apct_pkg.sv @@
// Shared constants, types and codes of the pair contact tracker.
`default_nettype none
package apct_pkg;

   // Sizing
   localparam int NUM_COLLIDERS = 32;
   localparam int COORD_BITS    = 16;
   localparam int FIELD_BITS    = 16;
   localparam int ID_BITS       = 5;
   localparam int ROW_BITS      = (NUM_COLLIDERS > 2) ? $clog2(NUM_COLLIDERS) : 1;
   localparam int SUM_BITS      = COORD_BITS + 1;
   localparam int MAG_BITS      = COORD_BITS + 2;

   // Transaction queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_BITS     = QCNT_BITS + 1;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_BEGIN = 2'd1,
      EV_STAY  = 2'd2,
      EV_END   = 2'd3
   } apct_event_type;

   typedef enum logic {
      BACK_LOAD,
      BACK_APPLY
   } apct_back_state_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic                id_ok;
      logic                any_dead;
      logic                touching;
      logic [ROW_BITS-1:0] row;
      logic [ROW_BITS-1:0] col;
   } apct_item_type;

   typedef struct packed {
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } apct_queue_status_type;

endpackage
`default_nettype wire

@@ sv/apct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module apct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/apct_front.sv @@
// Front end: accepts pairs, runs the box overlap test, pushes classified items.
`default_nettype none
module apct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [apct_pkg::ID_BITS-1:0]    req_left_id,
   input  wire logic [apct_pkg::ID_BITS-1:0]    req_right_id,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_x,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_y,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_x,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_y,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_w,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_h,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_w,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_h,
   input  wire logic                            req_left_dead,
   input  wire logic                            req_right_dead,
   input  wire apct_pkg::apct_queue_status_type q_status,
   output logic                                 q_push,
   output apct_pkg::apct_item_type              q_item
);

   // Field bits read as a COORD_BITS two's complement value
   function automatic logic signed [apct_pkg::COORD_BITS-1:0] coord_of(
      input logic [apct_pkg::FIELD_BITS-1:0] raw
   );
      logic [apct_pkg::COORD_BITS-1:0] bits;
      bits = apct_pkg::COORD_BITS'(raw);
      return signed'(bits);
   endfunction

   function automatic logic signed [apct_pkg::SUM_BITS-1:0] add_c(
      input logic [apct_pkg::FIELD_BITS-1:0] a,
      input logic [apct_pkg::FIELD_BITS-1:0] b
   );
      return apct_pkg::SUM_BITS'(coord_of(a)) + apct_pkg::SUM_BITS'(coord_of(b));
   endfunction

   function automatic logic signed [apct_pkg::SUM_BITS-1:0] sub_c(
      input logic [apct_pkg::FIELD_BITS-1:0] a,
      input logic [apct_pkg::FIELD_BITS-1:0] b
   );
      return apct_pkg::SUM_BITS'(coord_of(a)) - apct_pkg::SUM_BITS'(coord_of(b));
   endfunction

   function automatic logic [apct_pkg::MAG_BITS-1:0] mag_of(
      input logic signed [apct_pkg::SUM_BITS-1:0] v
   );
      logic signed [apct_pkg::MAG_BITS-1:0] w;
      w = apct_pkg::MAG_BITS'(v);
      return w[apct_pkg::MAG_BITS-1] ? unsigned'(-w) : unsigned'(w);
   endfunction

   logic                                 accept;
   logic [apct_pkg::FILL_BITS-1:0]       fill;

   logic                                 s1_valid_ff, s1_valid_in;
   logic signed [apct_pkg::SUM_BITS-1:0] span_x_ff, gap_x_ff, span_y_ff, gap_y_ff;
   logic                                 id_ok_ff, any_dead_ff;
   logic [apct_pkg::ROW_BITS-1:0]        row_ff, col_ff;

   logic [apct_pkg::MAG_BITS-1:0]        span_x_mag, gap_x_mag, span_y_mag, gap_y_mag;
   logic                                 hit_x, hit_y;

   // Room check: queued entries plus the one in the compute stage
   assign fill   = apct_pkg::FILL_BITS'(q_status.count) + apct_pkg::FILL_BITS'(s1_valid_ff);
   assign busy   = fill >= apct_pkg::FILL_BITS'(apct_pkg::QUEUE_DEPTH);
   assign accept = start && !busy;
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage 1: spans and gaps per axis, id range check
   always_ff @(posedge clock) begin
      if (accept) begin
         span_x_ff   <= add_c(req_left_w, req_right_w);
         span_y_ff   <= add_c(req_left_h, req_right_h);
         gap_x_ff    <= sub_c(req_left_x, req_right_x);
         gap_y_ff    <= sub_c(req_left_y, req_right_y);
         id_ok_ff    <= (int'(req_left_id) < apct_pkg::NUM_COLLIDERS) &&
                        (int'(req_right_id) < apct_pkg::NUM_COLLIDERS);
         any_dead_ff <= req_left_dead || req_right_dead;
         row_ff      <= apct_pkg::ROW_BITS'(req_left_id);
         col_ff      <= apct_pkg::ROW_BITS'(req_right_id);
      end
   end

   // Stage 2: |span| >= 2|gap| on both axes, then push
   always_comb begin
      span_x_mag = mag_of(span_x_ff);
      span_y_mag = mag_of(span_y_ff);
      gap_x_mag  = mag_of(gap_x_ff);
      gap_y_mag  = mag_of(gap_y_ff);
      hit_x      = span_x_mag >= {gap_x_mag[apct_pkg::MAG_BITS-2:0], 1'b0};
      hit_y      = span_y_mag >= {gap_y_mag[apct_pkg::MAG_BITS-2:0], 1'b0};

      q_push          = s1_valid_ff;
      q_item.id_ok    = id_ok_ff;
      q_item.any_dead = any_dead_ff;
      q_item.touching = hit_x && hit_y;
      q_item.row      = row_ff;
      q_item.col      = col_ff;
   end

endmodule
`default_nettype wire

@@ sv/apct_queue.sv @@
// Short register queue between the front and back ends.
`default_nettype none
module apct_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire apct_pkg::apct_item_type         push_item,
   input  wire logic                            pop,
   output apct_pkg::apct_item_type              head,
   output apct_pkg::apct_queue_status_type      status
);

   apct_pkg::apct_item_type          entry_ff [apct_pkg::QUEUE_DEPTH];
   logic [apct_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [apct_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [apct_pkg::QCNT_BITS-1:0]   count_ff, count_in;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule
`default_nettype wire

@@ sv/apct_back.sv @@
// Back end: contact table read-modify-write and event generation.
`default_nettype none
module apct_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire apct_pkg::apct_queue_status_type q_status,
   input  wire apct_pkg::apct_item_type         q_head,
   output logic                                 q_pop,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_event_res,
   output logic                                 rsp_touching
);

   apct_pkg::apct_back_state_type          state_ff, state_in;
   apct_pkg::apct_item_type                cur_ff, cur_in;
   logic [apct_pkg::NUM_COLLIDERS-1:0]     row_valid_ff, row_valid_in;

   logic                                   ram_rd_en;
   logic [apct_pkg::NUM_COLLIDERS-1:0]     ram_rd_data;
   logic                                   ram_wr_en;
   logic [apct_pkg::NUM_COLLIDERS-1:0]     ram_wr_data;

   logic [apct_pkg::NUM_COLLIDERS-1:0]     old_row;
   logic                                   prev;
   apct_pkg::apct_event_type               ev;

   logic                                   strobe_ff, strobe_in;
   apct_pkg::apct_event_type               event_ff, event_in;
   logic                                   touch_ff, touch_in;

   // One row per left id, one bit per right id
   apct_ram #(
      .WIDTH (apct_pkg::NUM_COLLIDERS),
      .DEPTH (apct_pkg::NUM_COLLIDERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_ff.row),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (q_head.row),
      .rd_data (ram_rd_data)
   );

   // Sequencer: load pops and reads the row, apply updates and reports
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      row_valid_in = row_valid_ff;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      strobe_in    = 1'b0;
      event_in     = event_ff;
      touch_in     = touch_ff;

      // a row never written since reset reads as all zeros
      old_row = row_valid_ff[cur_ff.row] ? ram_rd_data : '0;
      prev    = old_row[cur_ff.col];
      ram_wr_data = old_row;
      ram_wr_data[cur_ff.col] = cur_ff.touching;

      ev = apct_pkg::EV_NONE;
      if (cur_ff.id_ok) begin
         if (cur_ff.touching) begin
            if (!prev) begin
               ev = cur_ff.any_dead ? apct_pkg::EV_NONE : apct_pkg::EV_BEGIN;
            end else begin
               ev = cur_ff.any_dead ? apct_pkg::EV_END : apct_pkg::EV_STAY;
            end
         end else begin
            ev = prev ? apct_pkg::EV_END : apct_pkg::EV_NONE;
         end
      end

      case (state_ff)
         apct_pkg::BACK_LOAD: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               ram_rd_en = 1'b1;
               cur_in    = q_head;
               state_in  = apct_pkg::BACK_APPLY;
            end
         end
         apct_pkg::BACK_APPLY: begin
            ram_wr_en = cur_ff.id_ok;
            if (cur_ff.id_ok) begin
               row_valid_in[cur_ff.row] = 1'b1;
            end
            strobe_in = 1'b1;
            event_in  = ev;
            touch_in  = cur_ff.touching;
            state_in  = apct_pkg::BACK_LOAD;
         end
         default: begin
            state_in = apct_pkg::BACK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apct_pkg::BACK_LOAD;
         row_valid_ff <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      event_ff <= event_in;
      touch_ff <= touch_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_event_res = event_ff;
   assign rsp_touching  = touch_ff;

endmodule
`default_nettype wire

@@ sv/aabb_pair_contact_tracker_core.sv @@
// Top level of the AABB pair contact tracker: front, queue and back end.
//
//   channel   ports                          handshake
//   request   req_*  (left/right id, x, y,   start & !busy
//             w, h, dead)
//   response  rsp_event_res, rsp_touching    rsp_strobe, one cycle
//
// A back-end transaction runs through BACK_LOAD (pop and row read), then BACK_APPLY
// (row write and report), so the back end takes no new pair from the queue until
// it is through with the last one. The contact table is a
// 32-row RAM with one valid flip-flop per row, so reset needs no clearing pass:
// the block takes a pair in the cycle after reset drops. busy rises when the
// queue and the overlap stage hold QUEUE_DEPTH transactions.
`default_nettype none
`include "aabb_pair_contact_tracker_core_macros.svh"
module aabb_pair_contact_tracker_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [apct_pkg::ID_BITS-1:0]    req_left_id,
   input  wire logic [apct_pkg::ID_BITS-1:0]    req_right_id,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_x,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_y,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_x,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_y,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_w,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_left_h,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_w,
   input  wire logic [apct_pkg::FIELD_BITS-1:0] req_right_h,
   input  wire logic                            req_left_dead,
   input  wire logic                            req_right_dead,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_event_res,
   output logic                                 rsp_touching
);

   apct_pkg::apct_queue_status_type q_status;
   apct_pkg::apct_item_type         q_item;
   apct_pkg::apct_item_type         q_head;
   logic                            q_push;
   logic                            q_pop;

   apct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_left_id    (req_left_id),
      .req_right_id   (req_right_id),
      .req_left_x     (req_left_x),
      .req_left_y     (req_left_y),
      .req_right_x    (req_right_x),
      .req_right_y    (req_right_y),
      .req_left_w     (req_left_w),
      .req_left_h     (req_left_h),
      .req_right_w    (req_right_w),
      .req_right_h    (req_right_h),
      .req_left_dead  (req_left_dead),
      .req_right_dead (req_right_dead),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   apct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   apct_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_event_res (rsp_event_res),
      .rsp_touching  (rsp_touching)
   );

   // Checks
   `APCT_ASSERT_NEVER(a_no_overflow, q_push && !q_pop && (q_status.count == apct_pkg::QCNT_BITS'(apct_pkg::QUEUE_DEPTH)), "queue push while full")
   `APCT_ASSERT_NEVER(a_no_underflow, q_pop && q_status.empty, "queue pop while empty")
   `APCT_ASSERT_NEXT(a_strobe_spacing, rsp_strobe, !rsp_strobe, "back-to-back response strobes")
   `APCT_ASSERT_IMPLY(a_event_contact, rsp_strobe && !rsp_touching, (rsp_event_res != apct_pkg::EV_BEGIN) && (rsp_event_res != apct_pkg::EV_STAY), "begin or stay without contact")

endmodule
`default_nettype wire
